@@ rtl/core/srio_pkg.sv @@
package srio_pkg;

  // input pins sit below this number, output pins at and above OUTPUT_BASE
  localparam int unsigned INPUT_PINS  = 32;
  localparam int unsigned OUTPUT_BASE = 32;
  localparam int unsigned MAX_DEVICES = 4;
  localparam int unsigned WORD_BYTES  = 4;

  // action codes
  localparam logic [2:0] ACT_WRITE_BIT  = 3'd0;
  localparam logic [2:0] ACT_WRITE_BYTE = 3'd1;
  localparam logic [2:0] ACT_READ_BIT   = 3'd2;
  localparam logic [2:0] ACT_READ_BYTE  = 3'd3;
  localparam logic [2:0] ACT_START_SCAN = 3'd4;
  localparam logic [2:0] ACT_TICK       = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_READ_ENABLE   = 3'd0;
  localparam logic [2:0] REG_WRITE_ENABLE  = 3'd1;
  localparam logic [2:0] REG_READ_DEVICES  = 3'd2;
  localparam logic [2:0] REG_WRITE_DEVICES = 3'd3;
  localparam logic [2:0] REG_LATCH_TICKS   = 3'd4;
  localparam logic [2:0] REG_CLOCK_STYLE   = 3'd5;

  // configuration reset values
  localparam logic       RST_READ_ENABLE   = 1'b1;
  localparam logic       RST_WRITE_ENABLE  = 1'b1;
  localparam logic [2:0] RST_READ_DEVICES  = 3'd1;
  localparam logic [2:0] RST_WRITE_DEVICES = 3'd1;
  localparam logic [7:0] RST_LATCH_TICKS   = 8'd5;
  localparam logic       RST_CLOCK_STYLE   = 1'b0;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] pin;
    logic [7:0] value;
    logic       serial_in;
  } io_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_clock;
    logic       read_latch;
    logic       write_clock;
    logic       write_data;
    logic       write_latch;
    logic       busy_res;
  } io_out_t;

  // number of bits shifted for a device count register
  function automatic logic [5:0] chain_bits(input logic [2:0] devices);
    logic [2:0] n;
    n = devices;
    if (32'(n) > MAX_DEVICES) n = 3'(MAX_DEVICES);
    if (32'(n) > WORD_BYTES) n = 3'(WORD_BYTES);
    return {n, 3'b000};
  endfunction

endpackage

@@ rtl/core/shift_register_io_expander.sv @@
// Controller for a chain of parallel-in/serial-out input shift registers and a
// chain of serial-in/parallel-out output shift registers.
// Input channel (in_valid/in_ready/in_data): one transaction per action; write
// and read actions touch the stored 32-bit output and input words, start_scan
// begins a scan, tick advances a running scan by one latch tick or one serial
// clock half-phase, sampling serial_in while shifting in.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// accepted transaction, carrying read data, all chain line levels after the
// action, and the busy flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no transaction is outstanding.
// Latency: the result appears in the cycle after acceptance. Throughput: one
// transaction per cycle while the receiver takes each result; the action is
// decoded and the state updated in a single registered pass.
// A result stalled by the receiver holds the output register; a new
// transaction is still taken in the same cycle the held result leaves.
// Reset clears both words, marks a write as pending, returns the scan to idle
// and loads the configuration defaults.
module shift_register_io_expander (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srio_pkg::io_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srio_pkg::io_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RLATCH,
    PH_RSHIFT,
    PH_WLATCH,
    PH_WSHIFT
  } phase_t;

  // configuration registers
  logic       read_enable;
  logic       write_enable;
  logic [2:0] read_devices;
  logic [2:0] write_devices;
  logic [7:0] latch_ticks;
  logic       clock_style;

  // block state
  logic [31:0] input_word, input_word_next;
  logic [31:0] output_word, output_word_next;
  logic [31:0] shift_snapshot, shift_snapshot_next;
  logic        write_pending, write_pending_next;
  phase_t      phase, phase_next;
  logic [5:0]  bit_counter, bit_counter_next;
  logic [7:0]  latch_timer, latch_timer_next;
  logic        clock_half, clock_half_next;

  logic        accept;
  logic [7:0]  read_data_next;
  logic [7:0]  hold_time;
  logic [7:0]  timer_dec;
  logic [5:0]  bit_inc;
  logic [6:0]  pin_off;
  logic        pin_is_output;
  logic [1:0]  wr_byte_sel;
  logic [1:0]  rd_byte_sel;
  logic        write_go;
  logic        wdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // shared helpers for the action decode
  assign hold_time     = (latch_ticks == 8'd0) ? 8'd1 : latch_ticks;
  assign timer_dec     = (latch_timer != 8'd0) ? latch_timer - 8'd1 : latch_timer;
  assign bit_inc       = bit_counter + 6'd1;
  assign pin_is_output = {1'b0, in_data.pin} >= 7'(srio_pkg::OUTPUT_BASE);
  assign pin_off       = {1'b0, in_data.pin} - 7'(srio_pkg::OUTPUT_BASE);
  assign wr_byte_sel   = (pin_off >= 7'd24) ? 2'd3 : pin_off[4:3];
  assign rd_byte_sel   = (in_data.pin >= 6'd24) ? 2'd3 : in_data.pin[4:3];
  assign write_go      = write_enable && write_pending;

  // next state for one transaction
  always_comb begin
    input_word_next     = input_word;
    output_word_next    = output_word;
    shift_snapshot_next = shift_snapshot;
    write_pending_next  = write_pending;
    phase_next          = phase;
    bit_counter_next    = bit_counter;
    latch_timer_next    = latch_timer;
    clock_half_next     = clock_half;
    read_data_next      = 8'd0;
    unique case (in_data.action)
      srio_pkg::ACT_WRITE_BIT: begin
        if (pin_is_output && pin_off < 7'd32) begin
          output_word_next[pin_off[4:0]] = in_data.value[0];
          write_pending_next = 1'b1;
        end
      end
      srio_pkg::ACT_WRITE_BYTE: begin
        if (pin_is_output) begin
          output_word_next[{wr_byte_sel, 3'b000} +: 8] = in_data.value;
          write_pending_next = 1'b1;
        end
      end
      srio_pkg::ACT_READ_BIT: begin
        if (32'(in_data.pin) < srio_pkg::INPUT_PINS) begin
          read_data_next = {7'd0, input_word[in_data.pin[4:0]]};
        end
      end
      srio_pkg::ACT_READ_BYTE: begin
        read_data_next = input_word[{rd_byte_sel, 3'b000} +: 8];
      end
      srio_pkg::ACT_START_SCAN: begin
        if (phase == PH_IDLE) begin
          if (read_enable) begin
            phase_next       = PH_RLATCH;
            latch_timer_next = hold_time;
          end else if (write_go) begin
            phase_next       = PH_WLATCH;
            latch_timer_next = hold_time;
          end
        end
      end
      srio_pkg::ACT_TICK: begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_RLATCH: begin
            latch_timer_next = timer_dec;
            if (timer_dec == 8'd0) begin
              input_word_next = 32'd0;
              if (srio_pkg::chain_bits(read_devices) == 6'd0) begin
                if (write_go) begin
                  phase_next       = PH_WLATCH;
                  latch_timer_next = hold_time;
                end else begin
                  phase_next = PH_IDLE;
                end
              end else begin
                phase_next       = PH_RSHIFT;
                bit_counter_next = 6'd0;
                clock_half_next  = 1'b0;
              end
            end
          end
          PH_RSHIFT: begin
            if (!clock_half) begin
              input_word_next = {input_word[30:0], in_data.serial_in};
              clock_half_next = 1'b1;
            end else begin
              clock_half_next  = 1'b0;
              bit_counter_next = bit_inc;
              if (bit_inc >= srio_pkg::chain_bits(read_devices)) begin
                if (write_go) begin
                  phase_next       = PH_WLATCH;
                  latch_timer_next = hold_time;
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end
          end
          PH_WLATCH: begin
            latch_timer_next = timer_dec;
            if (timer_dec == 8'd0) begin
              shift_snapshot_next = output_word;
              write_pending_next  = 1'b0;
              if (srio_pkg::chain_bits(write_devices) == 6'd0) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next       = PH_WSHIFT;
                bit_counter_next = 6'd0;
                clock_half_next  = 1'b0;
              end
            end
          end
          PH_WSHIFT: begin
            if (!clock_half) begin
              clock_half_next = 1'b1;
            end else begin
              clock_half_next  = 1'b0;
              bit_counter_next = bit_inc;
              if (bit_inc >= srio_pkg::chain_bits(write_devices)) begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // serial data bit: bytes low first, each byte msb first
  assign wdata = (phase_next == PH_WSHIFT) ?
                 shift_snapshot_next[{bit_counter_next[4:3], ~bit_counter_next[2:0]}] : 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_enable   <= srio_pkg::RST_READ_ENABLE;
      write_enable  <= srio_pkg::RST_WRITE_ENABLE;
      read_devices  <= srio_pkg::RST_READ_DEVICES;
      write_devices <= srio_pkg::RST_WRITE_DEVICES;
      latch_ticks   <= srio_pkg::RST_LATCH_TICKS;
      clock_style   <= srio_pkg::RST_CLOCK_STYLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srio_pkg::REG_READ_ENABLE:   read_enable   <= cfg_data[0];
        srio_pkg::REG_WRITE_ENABLE:  write_enable  <= cfg_data[0];
        srio_pkg::REG_READ_DEVICES:  read_devices  <= cfg_data[2:0];
        srio_pkg::REG_WRITE_DEVICES: write_devices <= cfg_data[2:0];
        srio_pkg::REG_LATCH_TICKS:   latch_ticks   <= cfg_data;
        srio_pkg::REG_CLOCK_STYLE:   clock_style   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      input_word     <= 32'd0;
      output_word    <= 32'd0;
      shift_snapshot <= 32'd0;
      write_pending  <= 1'b1;
      phase          <= PH_IDLE;
      bit_counter    <= 6'd0;
      latch_timer    <= 8'd0;
      clock_half     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        input_word     <= input_word_next;
        output_word    <= output_word_next;
        shift_snapshot <= shift_snapshot_next;
        write_pending  <= write_pending_next;
        phase          <= phase_next;
        bit_counter    <= bit_counter_next;
        latch_timer    <= latch_timer_next;
        clock_half     <= clock_half_next;
        out_valid      <= 1'b1;
        // result payload
        out_data.read_data   <= read_data_next;
        out_data.read_clock  <= ((phase_next == PH_RSHIFT) && clock_half_next) ^ clock_style;
        out_data.read_latch  <= (phase_next != PH_RLATCH);
        out_data.write_clock <= (phase_next == PH_WSHIFT) && clock_half_next;
        out_data.write_data  <= wdata;
        out_data.write_latch <= !((phase_next == PH_WLATCH) || (phase_next == PH_WSHIFT));
        out_data.busy_res    <= (phase_next != PH_IDLE);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // shifting out never runs past the 32-bit snapshot
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WSHIFT) |-> (bit_counter < 6'd32))
    else $error("write shift counter out of range");

  // a latch phase always has time left to count down
  assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_RLATCH) || (phase == PH_WLATCH)) |-> (latch_timer != 8'd0))
    else $error("latch phase with expired timer");

  // an output clock pulse only happens while the output latch is held low
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.write_clock) |-> !out_data.write_latch)
    else $error("write clock pulse with latch high");

  // a scan started from idle with the input chain enabled begins with the read latch
  assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.action == srio_pkg::ACT_START_SCAN) && (phase == PH_IDLE)
     && read_enable) |=> (phase == PH_RLATCH))
    else $error("scan start did not enter read latch");
`endif

endmodule
